// ===== rtl/bbsf_pkg.sv =====
package bbsf_pkg;

    // Field widths of the stream items and the register
    localparam int OP_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 11;
    localparam int OFF_W     = 10;
    localparam int TOTAL_W   = 48;

    localparam int DEPTH_DEFAULT = 1024;
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 144;

    // Output tdata bit positions
    localparam int O_PUSH_ACC  = 0;
    localparam int O_REMOVED   = 1;
    localparam int O_PEEK_VLD  = 12;
    localparam int O_PEEK_BYTE = 13;
    localparam int O_COUNT     = 21;
    localparam int O_FREE      = 32;
    localparam int O_PUSHED    = 43;
    localparam int O_POPPED    = 91;
    localparam int O_CLOSED    = 139;
    localparam int O_FINISHED  = 140;
    localparam int O_ERROR     = 141;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_CLOSE = 3'd2,
        OP_ERROR = 3'd3,
        OP_QUERY = 3'd4
    } op_t;

endpackage

// ===== rtl/bbsf_ram.sv =====
module bbsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/bounded_byte_stream_fifo_top.sv =====
// Channel    Dir   tdata fields (low bit first)
// s_axis     in    operation, data_byte, pop_length, peek_offset
// m_axis     out   push_accepted, removed_now, peek_valid, peek_byte, buffered_count,
//                  free_space, pushed_total, popped_total, closed_flag, finished_flag,
//                  error_flag, 2 pad bits
// cfg        in    capacity_in_use (write enable + data)
//
// One transaction per cycle; a result shows in the cycle after its input is taken.
// The single read port of the byte store is read at the accepting edge; a byte written
// at that same edge reaches the result through a bypass register.
// Reset is asynchronous; the byte store needs no clearing pass.
// s_tready drops only while a result waits on m_axis with m_tready low.
module bounded_byte_stream_fifo_top #(
    parameter int DEPTH = bbsf_pkg::DEPTH_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bbsf_pkg::CNT_W-1:0]        cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation[2:0], data_byte[10:3], pop_length[21:11], peek_offset[31:22]
    input  logic [bbsf_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // push_accepted[0], removed_now[11:1], peek_valid[12], peek_byte[20:13],
    // buffered_count[31:21], free_space[42:32], pushed_total[90:43],
    // popped_total[138:91], closed_flag[139], finished_flag[140], error_flag[141]
    output logic [bbsf_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import bbsf_pkg::*;

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SUM_W   = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;
    localparam int CAP_LIM = (DEPTH > 2047) ? 2047 : DEPTH;

    logic [OP_W-1:0]    in_op;
    logic [BYTE_W-1:0]  in_byte;
    logic [CNT_W-1:0]   in_plen;
    logic [OFF_W-1:0]   in_off;

    logic               accept;

    logic [CNT_W-1:0]   cap_reg;
    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [ADDR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [TOTAL_W-1:0] pushed_reg, pushed_next;
    logic [TOTAL_W-1:0] popped_reg, popped_next;
    logic               closed_reg, closed_next;
    logic               error_reg, error_next;
    logic               out_valid_reg;

    logic               push_ok_reg, push_ok_next;
    logic [CNT_W-1:0]   removed_reg, removed_next;
    logic               peek_vld_reg, peek_vld_next;
    logic [CNT_W-1:0]   free_reg, free_next;
    logic               bypass_reg, bypass_next;
    logic [BYTE_W-1:0]  wbyte_reg;

    logic [CNT_W-1:0]   cap_eff;
    logic [SUM_W-1:0]   head_sum;
    logic [SUM_W-1:0]   peek_sum;
    logic [ADDR_W-1:0]  peek_addr;
    logic [BYTE_W-1:0]  ram_q;
    logic [BYTE_W-1:0]  peek_byte;

    assign in_op   = s_tdata[2:0];
    assign in_byte = s_tdata[10:3];
    assign in_plen = s_tdata[21:11];
    assign in_off  = s_tdata[31:22];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign cap_eff = (cap_reg > CNT_W'(CAP_LIM)) ? CNT_W'(CAP_LIM) : cap_reg;

    always_comb
    begin
        push_ok_next = 1'b0;
        removed_next = '0;
        closed_next  = closed_reg;
        error_next   = error_reg;
        unique case (op_t'(in_op))
            OP_PUSH:
            begin
                push_ok_next = (fill_reg < cap_eff);
            end
            OP_POP:
            begin
                removed_next = (in_plen < fill_reg) ? in_plen : fill_reg;
            end
            OP_CLOSE:
            begin
                closed_next = 1'b1;
            end
            OP_ERROR:
            begin
                error_next = 1'b1;
            end
            OP_QUERY:
            begin
            end
            default:
            begin
            end
        endcase

        fill_next   = fill_reg + CNT_W'(push_ok_next) - removed_next;
        pushed_next = pushed_reg + TOTAL_W'(push_ok_next);
        popped_next = popped_reg + TOTAL_W'(removed_next);

        if (push_ok_next)
        begin
            tail_next = (tail_reg == ADDR_W'(DEPTH - 1)) ? '0 : tail_reg + ADDR_W'(1);
        end
        else
        begin
            tail_next = tail_reg;
        end

        // removed never exceeds fill <= DEPTH, so one subtract wraps it
        head_sum = SUM_W'(head_reg) + SUM_W'(removed_next);
        if (head_sum >= SUM_W'(DEPTH))
        begin
            head_sum = head_sum - SUM_W'(DEPTH);
        end
        head_next = head_sum[ADDR_W-1:0];

        // address only matters when offset < fill, which keeps the sum below 2*DEPTH
        peek_sum = SUM_W'(head_next) + SUM_W'(in_off);
        if (peek_sum >= SUM_W'(DEPTH))
        begin
            peek_sum = peek_sum - SUM_W'(DEPTH);
        end
        peek_addr = peek_sum[ADDR_W-1:0];

        peek_vld_next = (CNT_W'(in_off) < fill_next);
        free_next     = (fill_next < cap_eff) ? cap_eff - fill_next : '0;
        bypass_next   = push_ok_next && (peek_addr == tail_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            pushed_reg    <= '0;
            popped_reg    <= '0;
            closed_reg    <= 1'b0;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                fill_reg      <= fill_next;
                pushed_reg    <= pushed_next;
                popped_reg    <= popped_next;
                closed_reg    <= closed_next;
                error_reg     <= error_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            push_ok_reg  <= push_ok_next;
            removed_reg  <= removed_next;
            peek_vld_reg <= peek_vld_next;
            free_reg     <= free_next;
            bypass_reg   <= bypass_next;
            wbyte_reg    <= in_byte;
        end
    end

    bbsf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && push_ok_next),
        .wr_addr (tail_reg),
        .wr_data (in_byte),
        .rd_en   (accept),
        .rd_addr (peek_addr),
        .rd_data (ram_q)
    );

    // the byte pushed by the same transaction is not yet in the read data
    assign peek_byte = !peek_vld_reg ? '0 : (bypass_reg ? wbyte_reg : ram_q);

    // state registers only move on accept, so they still match the held result
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        2'b00,
        error_reg,
        closed_reg && (fill_reg == '0),
        closed_reg,
        popped_reg,
        pushed_reg,
        free_reg,
        fill_reg,
        peek_byte,
        peek_vld_reg,
        removed_reg,
        push_ok_reg
    };

endmodule

// ===== rtl/bbsf_checker.sv =====
module bbsf_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bbsf_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import bbsf_pkg::*;

    // a stalled result holds its valid and its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // each input transaction yields a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after input transaction");

    a_finished_closed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[O_FINISHED] |-> m_tdata[O_CLOSED])
        else $error("finished without closed");

    a_peek_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[O_PEEK_VLD] |-> m_tdata[O_COUNT+CNT_W-1:O_COUNT] != '0)
        else $error("peek valid on empty buffer");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output empty");

endmodule

bind bounded_byte_stream_fifo_top bbsf_checker u_bbsf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
